@@ rtl/core/tct_pkg.sv @@
package tct_pkg;

  localparam int KIND_W   = 2;
  localparam int VALUE_W  = 8;
  localparam int COUNT_W  = 31;
  localparam int STATUS_W = 2;
  localparam int REG_W    = 5;
  localparam int CFG_IDX_W = 1;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
  localparam logic [REG_W-1:0]   REG_RESET = 5'd16;

  localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ADD   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_READ  = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_SAT   = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS = 1'b1;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_MODIFY,
    S_RESULT
  } state_t;

endpackage

@@ rtl/core/tct_ram.sv @@
module tct_ram #(
  parameter int WIDTH = 31,
  parameter int DEPTH = 256
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/core/two_way_count_table_core.sv @@
// Two-way count table: MAX_ROWS x MAX_COLS saturating counters in one RAM.
// Input channel (in_valid / in_stall) carries kind, row_value, col_value;
// an item is taken when in_valid is high and in_stall is low.
// Output channel (out_valid / out_stall) returns one cell_count and status
// per item, in order. A finished result sits in the output register while
// the next item is accepted; a stalled result holds until taken, and the
// next result waits behind it with in_stall high.
// Config channel (cfg_valid / cfg_ready, cfg_index, cfg_data) sets
// rows_in_use (index 0) and cols_in_use (index 1); cfg_ready is always high.
// The RAM read issues on the accepting edge. Add and read items then pass
// through S_MODIFY (modify and write back) and S_RESULT (result hand-off)
// to the output register; out-of-range and unused-kind items go straight to
// S_RESULT. One item is in work at a time, so the RAM read-modify-write
// never overlaps. A clear item sweeps the RAM one entry per cycle over all
// MAX_ROWS*MAX_COLS entries, then hands off its result through S_RESULT.
// Reset runs the same sweep before the first item is accepted (in_stall
// high meanwhile); both margins reset to 16.
module two_way_count_table_core #(
  parameter int MAX_ROWS = 16,
  parameter int MAX_COLS = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [tct_pkg::KIND_W-1:0]         kind,
  input  logic [tct_pkg::VALUE_W-1:0]        row_value,
  input  logic [tct_pkg::VALUE_W-1:0]        col_value,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [tct_pkg::COUNT_W-1:0]        cell_count,
  output logic [tct_pkg::STATUS_W-1:0]       status,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [tct_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [tct_pkg::REG_W-1:0]          cfg_data
);

  localparam int Depth = MAX_ROWS * MAX_COLS;
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int RowW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int ColW  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam logic [tct_pkg::VALUE_W:0] RowMax  = (tct_pkg::VALUE_W + 1)'(MAX_ROWS);
  localparam logic [tct_pkg::VALUE_W:0] ColMax  = (tct_pkg::VALUE_W + 1)'(MAX_COLS);
  localparam logic [AddrW-1:0]          LastAddr = AddrW'(Depth - 1);

  tct_pkg::state_t state, state_next;

  logic [tct_pkg::REG_W-1:0]    rows_in_use;
  logic [tct_pkg::REG_W-1:0]    cols_in_use;
  logic [tct_pkg::KIND_W-1:0]   op_kind;
  logic [AddrW-1:0]             op_addr;
  logic [AddrW-1:0]             clr_addr;
  logic                         clr_reply;
  logic [tct_pkg::COUNT_W-1:0]  res_count;
  logic [tct_pkg::STATUS_W-1:0] res_status;

  logic                         in_fire;
  logic                         out_free;
  logic                         clr_last;
  logic                         row_ok;
  logic                         col_ok;
  logic                         pair_ok;
  logic                         kind_cell;
  logic [RowW-1:0]              row_idx;
  logic [ColW-1:0]              col_idx;
  logic [AddrW-1:0]             in_addr;
  logic                         mem_we;
  logic [AddrW-1:0]             mem_waddr;
  logic [tct_pkg::COUNT_W-1:0]  mem_wdata;
  logic [tct_pkg::COUNT_W-1:0]  mem_rdata;
  logic                         sat;
  logic [tct_pkg::COUNT_W-1:0]  mod_count;

  assign cfg_ready = 1'b1;
  assign in_fire   = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign clr_last  = (clr_addr == LastAddr);

  assign row_ok = (row_value != '0) && ({1'b0, row_value} <= RowMax) &&
                  (row_value <= {{(tct_pkg::VALUE_W - tct_pkg::REG_W){1'b0}}, rows_in_use});
  assign col_ok = (col_value != '0) && ({1'b0, col_value} <= ColMax) &&
                  (col_value <= {{(tct_pkg::VALUE_W - tct_pkg::REG_W){1'b0}}, cols_in_use});
  assign pair_ok   = row_ok && col_ok;
  assign kind_cell = (kind == tct_pkg::KIND_ADD) || (kind == tct_pkg::KIND_READ);

  assign row_idx = RowW'(row_value - 8'd1);
  assign col_idx = ColW'(col_value - 8'd1);
  assign in_addr = AddrW'(row_idx) * AddrW'(MAX_COLS) + AddrW'(col_idx);

  assign sat       = (mem_rdata == tct_pkg::COUNT_MAX);
  assign mod_count = (op_kind == tct_pkg::KIND_ADD && !sat) ? mem_rdata + 1'b1 : mem_rdata;

  always_comb begin
    state_next = state;
    unique case (state)
      tct_pkg::S_CLEAR: begin
        if (clr_last) begin
          state_next = clr_reply ? tct_pkg::S_RESULT : tct_pkg::S_IDLE;
        end
      end
      tct_pkg::S_IDLE: begin
        if (in_fire) begin
          if (kind == tct_pkg::KIND_CLEAR) begin
            state_next = tct_pkg::S_CLEAR;
          end else if (kind_cell && pair_ok) begin
            state_next = tct_pkg::S_MODIFY;
          end else begin
            state_next = tct_pkg::S_RESULT;
          end
        end
      end
      tct_pkg::S_MODIFY: begin
        state_next = tct_pkg::S_RESULT;
      end
      tct_pkg::S_RESULT: begin
        if (out_free) begin
          state_next = tct_pkg::S_IDLE;
        end
      end
      default: state_next = tct_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_stall  = 1'b1;
    mem_we    = 1'b0;
    mem_waddr = op_addr;
    mem_wdata = mod_count;
    unique case (state)
      tct_pkg::S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr;
        mem_wdata = '0;
      end
      tct_pkg::S_IDLE: begin
        in_stall = 1'b0;
      end
      tct_pkg::S_MODIFY: begin
        mem_we = (op_kind == tct_pkg::KIND_ADD) && !sat;
      end
      tct_pkg::S_RESULT: begin
        in_stall = 1'b1;
      end
      default: in_stall = 1'b1;
    endcase
  end

  tct_ram #(
    .WIDTH (tct_pkg::COUNT_W),
    .DEPTH (Depth)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (in_fire),
    .raddr (in_addr),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= tct_pkg::S_CLEAR;
      clr_addr    <= '0;
      clr_reply   <= 1'b0;
      out_valid   <= 1'b0;
      rows_in_use <= tct_pkg::REG_RESET;
      cols_in_use <= tct_pkg::REG_RESET;
    end else begin
      state <= state_next;
      if (state == tct_pkg::S_CLEAR) begin
        if (clr_last) begin
          clr_addr  <= '0;
          clr_reply <= 1'b0;
        end else begin
          clr_addr <= clr_addr + 1'b1;
        end
      end
      if (in_fire && kind == tct_pkg::KIND_CLEAR) begin
        clr_reply <= 1'b1;
      end
      if (state == tct_pkg::S_RESULT && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          tct_pkg::CFG_ROWS: rows_in_use <= cfg_data;
          tct_pkg::CFG_COLS: cols_in_use <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_kind    <= kind;
      op_addr    <= in_addr;
      res_count  <= '0;
      res_status <= (kind == tct_pkg::KIND_CLEAR) ? tct_pkg::ST_OK : tct_pkg::ST_RANGE;
    end
    if (state == tct_pkg::S_MODIFY) begin
      res_count  <= mod_count;
      res_status <= (op_kind == tct_pkg::KIND_ADD && sat) ? tct_pkg::ST_SAT : tct_pkg::ST_OK;
    end
    if (state == tct_pkg::S_RESULT && out_free) begin
      cell_count <= res_count;
      status     <= res_status;
    end
  end

endmodule

@@ rtl/core/tct_checker.sv @@
module tct_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [tct_pkg::COUNT_W-1:0]   cell_count,
  input logic [tct_pkg::STATUS_W-1:0]  status
);

  a_clear_after_reset: assert property (@(posedge clk) rst |=> in_stall)
    else $error("input taken during reset clearing pass");

  a_one_in_work: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("second item taken while one is in work");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(cell_count) && $stable(status))
    else $error("stalled result changed");

  a_range_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == tct_pkg::ST_RANGE) |-> (cell_count == '0))
    else $error("rejected item reports nonzero count");

  a_sat_max: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == tct_pkg::ST_SAT) |-> (cell_count == tct_pkg::COUNT_MAX))
    else $error("saturated status without full count");

endmodule

bind two_way_count_table_core tct_checker u_chk (.*);
